// File: hdl/spsort_pkg.sv
// ----------------------------------------------------------------------------
// spsort_pkg
// Shared codes and controller/datapath interface types of the sprite sorter.
// ----------------------------------------------------------------------------
package spsort_pkg;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_LIST   = 1'b1;

  localparam logic [15:0] KEY_IDLE = 16'hFFFF;
  localparam int          X_SHIFT  = 8;

  typedef struct packed {
    logic load_upd;
    logic load_list;
    logic det;
    logic seek;
    logic walk_step;
    logic link1;
    logic link2;
    logic emit;
  } spsort_ctl_t;

  typedef struct packed {
    logic s_ok;
    logic cur_ok;
    logic key_le;
    logic fin;
    logic out_free;
  } spsort_sts_t;

endpackage

// File: hdl/sprite_priority_sorter_top.sv
// ----------------------------------------------------------------------------
// sprite_priority_sorter_top
// Keeps sprites in a doubly linked list sorted by {x, index}; lists on demand.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | fields
//  in      | input     | in_valid_i/in_stall_o | command_i, sprite_index_i,
//          |           |                       | x_position_i
//  out     | output    | out_valid_o/out_stall_i | sprite_out_o, last_o
//
//  Update: detach, seek, walk past the k sprites ahead of the new place
//  (k up to SPRITE_COUNT - 1), then relink; one walk step per cycle, paced
//  by the registered key/link memory read. Out-of-range update: dropped.
//  List: one item per cycle, SPRITE_COUNT items, slowed by out_stall_i.
//  Reset clears the link/key valid bits; memories need no clearing pass.
// ----------------------------------------------------------------------------
module sprite_priority_sorter_top import spsort_pkg::*; #(
  parameter int unsigned SPRITE_COUNT = 40
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [5:0] sprite_index_i,
  input  logic [7:0] x_position_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] sprite_out_o,
  output logic       last_o
);

  spsort_ctl_t ctl;
  spsort_sts_t sts;

  spsort_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  spsort_dp #(
    .SPRITE_COUNT (SPRITE_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .sprite_index_i (sprite_index_i),
    .x_position_i   (x_position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sprite_out_o   (sprite_out_o),
    .last_o         (last_o)
  );

endmodule

// File: hdl/spsort_ctrl.sv
// ----------------------------------------------------------------------------
// spsort_ctrl
// Sequencer: accepts one item, then steps detach, seek, walk, relink or list.
// ----------------------------------------------------------------------------
module spsort_ctrl import spsort_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        command_i,
  output logic        in_stall_o,
  input  spsort_sts_t sts_i,
  output spsort_ctl_t ctl_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DET   = 3'd1;
  localparam logic [2:0] ST_SEEK  = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_LINK1 = 3'd4;
  localparam logic [2:0] ST_LINK2 = 3'd5;
  localparam logic [2:0] ST_LIST  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_LIST) begin
            ctl_o.load_list = 1'b1;
            state_d         = ST_LIST;
          end else if (sts_i.s_ok) begin
            ctl_o.load_upd = 1'b1;
            state_d        = ST_DET;
          end
        end
      end
      ST_DET: begin
        ctl_o.det = 1'b1;
        state_d   = ST_SEEK;
      end
      ST_SEEK: begin
        ctl_o.seek = 1'b1;
        state_d    = ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.cur_ok && sts_i.key_le) begin
          ctl_o.walk_step = 1'b1;
        end else begin
          state_d = ST_LINK1;
        end
      end
      ST_LINK1: begin
        ctl_o.link1 = 1'b1;
        state_d     = ST_LINK2;
      end
      ST_LINK2: begin
        ctl_o.link2 = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_LIST: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          if (sts_i.fin) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/spsort_dp.sv
// ----------------------------------------------------------------------------
// spsort_dp
// Key and link memories, walk cursor, head pointer and output register.
// ----------------------------------------------------------------------------
module spsort_dp import spsort_pkg::*; #(
  parameter int unsigned SPRITE_COUNT = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  spsort_ctl_t ctl_i,
  output spsort_sts_t sts_o,
  input  logic [5:0]  sprite_index_i,
  input  logic [7:0]  x_position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  sprite_out_o,
  output logic        last_o
);

  localparam int IW = $clog2(SPRITE_COUNT);
  localparam int LW = $clog2(SPRITE_COUNT + 1);
  localparam logic [LW-1:0] LINK_END = LW'(SPRITE_COUNT);
  localparam logic [LW-1:0] LAST_CNT = LW'(SPRITE_COUNT - 1);

  logic [LW-1:0] next_mem [SPRITE_COUNT];
  logic [LW-1:0] prev_mem [SPRITE_COUNT];
  logic [15:0]   key_mem  [SPRITE_COUNT];

  logic [SPRITE_COUNT-1:0] next_vld_q, prev_vld_q, key_vld_q;
  logic                    next_vq, prev_vq, key_vq;
  logic [LW-1:0]           next_rq, prev_rq;
  logic [15:0]             key_rq;
  logic [IW-1:0]           rd_addr, rd_addr_q;

  logic [LW-1:0] next_rd, prev_rd, next_rst, prev_rst;
  logic [15:0]   key_rd;

  logic [LW-1:0] cur_q, cur_d, prior_q, prior_d, head_q, head_d, cnt_q, cnt_d;
  logic [LW-1:0] s_q, s_in;
  logic [15:0]   key_q, key_in;

  logic          nw_en, pw_en, kw_en;
  logic [IW-1:0] nw_addr, pw_addr, kw_addr;
  logic [LW-1:0] nw_data, pw_data;

  logic       out_valid_q;
  logic [5:0] out_sprite_q;
  logic       out_last_q;

  assign s_in   = LW'(sprite_index_i);
  assign key_in = (16'(x_position_i) << X_SHIFT) | 16'(sprite_index_i);

  // unwritten entries read as their reset values
  assign next_rst = LW'(rd_addr_q) + LW'(1);
  assign prev_rst = (rd_addr_q == '0) ? LINK_END : LW'(rd_addr_q) - LW'(1);
  assign next_rd  = next_vq ? next_rq : next_rst;
  assign prev_rd  = prev_vq ? prev_rq : prev_rst;
  assign key_rd   = key_vq  ? key_rq  : KEY_IDLE;

  assign sts_o.s_ok     = {1'b0, sprite_index_i} < 7'(SPRITE_COUNT);
  assign sts_o.cur_ok   = cur_q < LINK_END;
  assign sts_o.key_le   = key_rd <= key_q;
  assign sts_o.fin      = (next_rd >= LINK_END) || (cnt_q == LAST_CNT);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cur_d   = cur_q;
    prior_d = prior_q;
    cnt_d   = cnt_q;
    if (ctl_i.load_upd) begin
      cur_d = s_in;
    end else if (ctl_i.load_list) begin
      cur_d = head_q;
      cnt_d = '0;
    end else if (ctl_i.seek) begin
      cur_d   = head_q;
      prior_d = LINK_END;
    end else if (ctl_i.walk_step) begin
      prior_d = cur_q;
      cur_d   = next_rd;
    end else if (ctl_i.emit) begin
      cur_d = next_rd;
      cnt_d = cnt_q + LW'(1);
    end
  end

  assign rd_addr = (cur_d < LINK_END) ? cur_d[IW-1:0] : '0;

  always_comb begin
    nw_en   = 1'b0;
    nw_addr = '0;
    nw_data = '0;
    pw_en   = 1'b0;
    pw_addr = '0;
    pw_data = '0;
    kw_en   = 1'b0;
    kw_addr = s_q[IW-1:0];
    head_d  = head_q;
    if (ctl_i.det) begin
      kw_en = 1'b1;
      if (prev_rd < LINK_END) begin
        nw_en   = 1'b1;
        nw_addr = prev_rd[IW-1:0];
        nw_data = next_rd;
      end else begin
        head_d = next_rd;
      end
      if (next_rd < LINK_END) begin
        pw_en   = 1'b1;
        pw_addr = next_rd[IW-1:0];
        pw_data = prev_rd;
      end
    end else if (ctl_i.link1) begin
      nw_en   = 1'b1;
      nw_addr = s_q[IW-1:0];
      nw_data = cur_q;
      pw_en   = 1'b1;
      pw_addr = s_q[IW-1:0];
      pw_data = prior_q;
      if (prior_q >= LINK_END) begin
        head_d = s_q;
      end
    end else if (ctl_i.link2) begin
      if (prior_q < LINK_END) begin
        nw_en   = 1'b1;
        nw_addr = prior_q[IW-1:0];
        nw_data = s_q;
      end
      if (cur_q < LINK_END) begin
        pw_en   = 1'b1;
        pw_addr = cur_q[IW-1:0];
        pw_data = s_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    next_rq <= next_mem[rd_addr];
    prev_rq <= prev_mem[rd_addr];
    key_rq  <= key_mem[rd_addr];
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    if (pw_en) begin
      prev_mem[pw_addr] <= pw_data;
    end
    if (kw_en) begin
      key_mem[kw_addr] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr;
    if (ctl_i.load_upd) begin
      s_q   <= s_in;
      key_q <= key_in;
    end
    if (ctl_i.emit) begin
      out_sprite_q <= 6'(cur_q);
      out_last_q   <= sts_o.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_vld_q  <= '0;
      prev_vld_q  <= '0;
      key_vld_q   <= '0;
      next_vq     <= 1'b0;
      prev_vq     <= 1'b0;
      key_vq      <= 1'b0;
      cur_q       <= '0;
      prior_q     <= LINK_END;
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      next_vq <= next_vld_q[rd_addr];
      prev_vq <= prev_vld_q[rd_addr];
      key_vq  <= key_vld_q[rd_addr];
      if (nw_en) begin
        next_vld_q[nw_addr] <= 1'b1;
      end
      if (pw_en) begin
        prev_vld_q[pw_addr] <= 1'b1;
      end
      if (kw_en) begin
        key_vld_q[kw_addr] <= 1'b1;
      end
      cur_q   <= cur_d;
      prior_q <= prior_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      if (ctl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sprite_out_o = out_sprite_q;
  assign last_o       = out_last_q;

  a_head_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < LINK_END)
    else $error("head pointer out of range");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LINK_END)
    else $error("listing ran past the sprite count");

  a_det_no_self_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.det |-> (next_rd != cur_q) && (prev_rd != cur_q))
    else $error("detached sprite links to itself");

  a_emit_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit |-> sts_o.out_free)
    else $error("item emitted over a held output");

endmodule
